// ----- rtl/core/windowed_zscore_spike_detector_macros.svh -----
// Assertion helpers shared by the spike detector modules.
// They expect the clock clk and the active-low reset rst_n in scope.
`ifndef WINDOWED_ZSCORE_SPIKE_DETECTOR_MACROS_SVH
`define WINDOWED_ZSCORE_SPIKE_DETECTOR_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define WZSD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define WZSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/wzsd_pkg.sv -----
`default_nettype none
package wzsd_pkg;

  localparam int KEY_W    = 16;
  localparam int FREQ_W   = 20;
  localparam int STAMP_W  = 32;
  localparam int SEV_W    = 17;
  localparam int AVG_W    = 28;
  localparam int CNTO_W   = 11;

  // Arithmetic widths sized for the largest supported window depth (65536).
  localparam int N_W      = 17;
  localparam int SUM_W    = 36;
  localparam int SQ_W     = 40;
  localparam int SUMSQ_W  = 56;
  localparam int NL_W     = N_W + FREQ_W;
  localparam int V_W      = 72;
  localparam int SC_W     = SUM_W + 16;
  localparam int RHS_W    = 2 * SC_W;
  localparam int F2_W     = 37;
  localparam int MB_W     = SC_W;
  localparam int MP_W     = 128;
  localparam int STEP_W   = 6;
  localparam int DIVN_W   = SUM_W + 8;

  localparam logic [FREQ_W-1:0] FREQ_CLAMP = 20'd1000000;
  localparam logic [SEV_W-1:0]  SEV_ONE    = 17'd65536;
  localparam logic [2:0]        SEV_SCALE  = 3'd5;
  localparam logic [31:0]       WINDOW_RST = 32'd86400;

  localparam logic [1:0] KIND_ADD   = 2'd0;
  localparam logic [1:0] KIND_QUERY = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  typedef struct packed {
    logic [1:0]         kind;
    logic [KEY_W-1:0]   term_key;
    logic [FREQ_W-1:0]  frequency;
    logic [STAMP_W-1:0] stamp_seconds;
    logic [STAMP_W-1:0] now_seconds;
  } in_t;

  typedef struct packed {
    logic [SEV_W-1:0]  severity;
    logic [AVG_W-1:0]  average_frequency;
    logic [CNTO_W-1:0] match_count;
    logic [CNTO_W-1:0] live_entries;
    logic              status;
  } out_t;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [FREQ_W-1:0]  freq;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [1:0] {
    MUL_NSQ = 2'd0,
    MUL_SS  = 2'd1,
    MUL_RHS = 2'd2,
    MUL_VF  = 2'd3
  } mul_op_t;

  typedef struct packed {
    logic    load;
    logic    clear;
    logic    pop;
    logic    rd_oldest;
    logic    write_new;
    logic    scan_init;
    logic    scan_step;
    logic    nl_calc;
    logic    div_start;
    logic    mul_start;
    mul_op_t mul_op;
    logic    sev_init;
    logic    sev_f2;
    logic    out_fire;
  } ctrl_cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic expired;
    logic scan_done;
    logic n_zero;
    logic mul_done;
    logic sev_ok;
    logic search_open;
    logic div_busy;
  } dp_stat_t;

endpackage
`default_nettype wire

// ----- rtl/core/windowed_zscore_spike_detector.sv -----
// Channel   Handshake                     Payload
// input     start, accepted when !busy    in_data  (in_t)
// result    out_valid, one-cycle strobe   out_data (out_t)
// config    cfg_valid / cfg_ready         cfg_data (window length, seconds)
//
// An item first pops every expired entry from the oldest end of the ring. A query
// also scans every live entry through the single RAM read port, then runs three
// shift-add multiplies and up to 17 binary search steps for the severity. Clear
// and unused kinds go straight to the result. Reset is synchronous; the ring
// needs no clearing pass. The result stays for one cycle and cannot be stalled.
`default_nettype none
module windowed_zscore_spike_detector #(
  parameter int WINDOW_DEPTH = 1024
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  output      logic           busy,
  input  wire wzsd_pkg::in_t  in_data,
  output      logic           out_valid,
  output      wzsd_pkg::out_t out_data,
  input  wire logic           cfg_valid,
  output      logic           cfg_ready,
  input  wire logic [31:0]    cfg_data
);

  wzsd_pkg::ctrl_cmd_t cmd;
  wzsd_pkg::dp_stat_t  stat;

  assign cfg_ready = 1'b1;

  wzsd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_kind   (in_data.kind),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  wzsd_dp #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule
`default_nettype wire

// ----- rtl/core/wzsd_ram.sv -----
`default_nettype none
module wzsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ----- rtl/core/wzsd_ctrl.sv -----
`default_nettype none
`include "windowed_zscore_spike_detector_macros.svh"
module wzsd_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic [1:0]           in_kind,
  input  wire wzsd_pkg::dp_stat_t   stat,
  output      wzsd_pkg::ctrl_cmd_t  cmd,
  output      logic                 busy,
  output      logic                 out_valid
);

  typedef enum logic [14:0] {
    S_IDLE     = 15'b000000000000001,
    S_EXP_RD   = 15'b000000000000010,
    S_EXP_CHK  = 15'b000000000000100,
    S_ADD      = 15'b000000000001000,
    S_SCAN     = 15'b000000000010000,
    S_NL       = 15'b000000000100000,
    S_MUL_NSQ  = 15'b000000001000000,
    S_MUL_SS   = 15'b000000010000000,
    S_SEV_CHK  = 15'b000000100000000,
    S_MUL_RHS  = 15'b000001000000000,
    S_SEV_F2   = 15'b000010000000000,
    S_SEV_MUL  = 15'b000100000000000,
    S_SEV_WAIT = 15'b001000000000000,
    S_DIV_WAIT = 15'b010000000000000,
    S_DONE     = 15'b100000000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   is_query_r, is_query_nxt;
  logic   out_valid_r;

  always_comb begin
    state_nxt    = state_r;
    is_query_nxt = is_query_r;
    cmd          = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load     = 1'b1;
          is_query_nxt = (in_kind == wzsd_pkg::KIND_QUERY);
          if (in_kind == wzsd_pkg::KIND_ADD || in_kind == wzsd_pkg::KIND_QUERY) begin
            state_nxt = S_EXP_RD;
          end else begin
            cmd.clear = (in_kind == wzsd_pkg::KIND_CLEAR);
            state_nxt = S_DONE;
          end
        end
      end
      S_EXP_RD: begin
        if (stat.cnt_zero) begin
          if (is_query_r) begin
            cmd.scan_init = 1'b1;
            state_nxt     = S_SCAN;
          end else begin
            state_nxt = S_ADD;
          end
        end else begin
          cmd.rd_oldest = 1'b1;
          state_nxt     = S_EXP_CHK;
        end
      end
      S_EXP_CHK: begin
        if (stat.expired) begin
          cmd.pop   = 1'b1;
          state_nxt = S_EXP_RD;
        end else if (is_query_r) begin
          cmd.scan_init = 1'b1;
          state_nxt     = S_SCAN;
        end else begin
          state_nxt = S_ADD;
        end
      end
      S_ADD: begin
        cmd.write_new = 1'b1;
        state_nxt     = S_DONE;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_done) begin
          state_nxt = stat.n_zero ? S_DONE : S_NL;
        end
      end
      S_NL: begin
        cmd.nl_calc   = 1'b1;
        cmd.div_start = 1'b1;
        cmd.mul_start = 1'b1;
        cmd.mul_op    = wzsd_pkg::MUL_NSQ;
        state_nxt     = S_MUL_NSQ;
      end
      S_MUL_NSQ: begin
        if (stat.mul_done) begin
          cmd.mul_start = 1'b1;
          cmd.mul_op    = wzsd_pkg::MUL_SS;
          state_nxt     = S_MUL_SS;
        end
      end
      S_MUL_SS: begin
        if (stat.mul_done) begin
          state_nxt = S_SEV_CHK;
        end
      end
      S_SEV_CHK: begin
        if (stat.sev_ok) begin
          cmd.mul_start = 1'b1;
          cmd.mul_op    = wzsd_pkg::MUL_RHS;
          state_nxt     = S_MUL_RHS;
        end else begin
          state_nxt = S_DIV_WAIT;
        end
      end
      S_MUL_RHS: begin
        if (stat.mul_done) begin
          cmd.sev_init = 1'b1;
          state_nxt    = S_SEV_F2;
        end
      end
      S_SEV_F2: begin
        if (stat.search_open) begin
          cmd.sev_f2 = 1'b1;
          state_nxt  = S_SEV_MUL;
        end else begin
          state_nxt = S_DIV_WAIT;
        end
      end
      S_SEV_MUL: begin
        cmd.mul_start = 1'b1;
        cmd.mul_op    = wzsd_pkg::MUL_VF;
        state_nxt     = S_SEV_WAIT;
      end
      S_SEV_WAIT: begin
        if (stat.mul_done) begin
          state_nxt = S_SEV_F2;
        end
      end
      S_DIV_WAIT: begin
        if (!stat.div_busy) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        cmd.out_fire = 1'b1;
        state_nxt    = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      is_query_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      is_query_r  <= is_query_nxt;
      out_valid_r <= cmd.out_fire;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  `WZSD_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not make the block busy")
  `WZSD_ASSERT_NEXT(a_done_strobe, state_r == S_DONE, out_valid_r, "finished item gave no result")
  `WZSD_ASSERT_NOW(a_strobe_idle, out_valid_r, state_r == S_IDLE, "result shown while not idle")

endmodule
`default_nettype wire

// ----- rtl/core/wzsd_dp.sv -----
`default_nettype none
`include "windowed_zscore_spike_detector_macros.svh"
module wzsd_dp #(
  parameter int WINDOW_DEPTH = 1024
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire wzsd_pkg::in_t        in_data,
  input  wire logic                 cfg_we,
  input  wire logic [31:0]          cfg_data,
  input  wire wzsd_pkg::ctrl_cmd_t  cmd,
  output      wzsd_pkg::dp_stat_t   stat,
  output      wzsd_pkg::out_t       out_data
);

  localparam int AW = $clog2(WINDOW_DEPTH);
  localparam int CW = $clog2(WINDOW_DEPTH + 1);

  wzsd_pkg::in_t  in_r;
  wzsd_pkg::out_t out_r;
  logic [31:0]    window_r;
  logic [AW-1:0]  oldest_r;
  logic [CW-1:0]  count_r;
  logic           status_r;

  // Ring storage.
  logic                         ram_we, ram_re;
  logic [AW-1:0]                ram_waddr, ram_raddr;
  logic [wzsd_pkg::ENTRY_W-1:0] ram_rdata;
  wzsd_pkg::entry_t             new_entry, rd_entry;

  wzsd_ram #(
    .WIDTH (wzsd_pkg::ENTRY_W),
    .DEPTH (WINDOW_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (new_entry),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_entry = wzsd_pkg::entry_t'(ram_rdata);

  logic [AW+1:0] tail_sum;
  logic [AW-1:0] tail_slot, oldest_inc;
  logic          full;

  assign tail_sum   = {2'b00, oldest_r} + {{(AW+2-CW){1'b0}}, count_r};
  assign tail_slot  = (tail_sum >= (AW+2)'(WINDOW_DEPTH))
                    ? AW'(tail_sum - (AW+2)'(WINDOW_DEPTH)) : tail_sum[AW-1:0];
  assign oldest_inc = (oldest_r == AW'(WINDOW_DEPTH - 1)) ? '0 : oldest_r + 1'b1;
  assign full       = (count_r == CW'(WINDOW_DEPTH));

  assign new_entry.key   = in_r.term_key;
  assign new_entry.freq  = in_r.frequency;
  assign new_entry.stamp = in_r.stamp_seconds;

  // Age is signed: a stamp ahead of the current time never expires.
  logic signed [32:0] age;
  assign age = $signed({1'b0, in_r.now_seconds}) - $signed({1'b0, rd_entry.stamp});

  // Scan pipeline: read, match and clamp, square, accumulate.
  logic [CW-1:0]                  scan_idx_r;
  logic [AW-1:0]                  scan_slot_r;
  logic                           scan_issue;
  logic                           p1_v_r, p2_v_r, p3_v_r;
  logic [wzsd_pkg::FREQ_W-1:0]    f2s_r, f3_r, clamped;
  logic [wzsd_pkg::SQ_W-1:0]      sq_r;
  logic [wzsd_pkg::N_W-1:0]       n_r;
  logic [wzsd_pkg::SUM_W-1:0]     sum_r;
  logic [wzsd_pkg::SUMSQ_W-1:0]   sumsq_r;
  logic [wzsd_pkg::FREQ_W-1:0]    latest_r;

  assign scan_issue = cmd.scan_step && (scan_idx_r != count_r);
  assign clamped    = (rd_entry.freq > wzsd_pkg::FREQ_CLAMP) ? wzsd_pkg::FREQ_CLAMP
                                                            : rd_entry.freq;

  assign ram_we    = cmd.write_new && !full;
  assign ram_waddr = tail_slot;
  assign ram_re    = cmd.rd_oldest || scan_issue;
  assign ram_raddr = cmd.rd_oldest ? oldest_r : scan_slot_r;

  // Statistics.
  logic [wzsd_pkg::NL_W-1:0]  nl_r;
  logic [wzsd_pkg::V_W-1:0]   nsq_r, v_r;
  logic [wzsd_pkg::RHS_W-1:0] rhs_r;
  logic [wzsd_pkg::NL_W-1:0]  dev;
  logic [wzsd_pkg::SC_W-1:0]  scaled;
  logic [wzsd_pkg::F2_W-1:0]  f2_r;

  assign dev    = nl_r - {{(wzsd_pkg::NL_W-wzsd_pkg::SUM_W){1'b0}}, sum_r};
  assign scaled = {dev[wzsd_pkg::SUM_W-1:0], 16'h0000};

  // Shift-add multiplier, one multiplier bit per cycle.
  logic [wzsd_pkg::MP_W-1:0]   mul_a_r, mul_acc_r, mul_sum, mul_a_in;
  logic [wzsd_pkg::MB_W-1:0]   mul_b_r, mul_b_in;
  logic [wzsd_pkg::STEP_W-1:0] mul_cnt_r;
  logic                        mul_busy_r, mul_done;
  wzsd_pkg::mul_op_t           mul_op_r;

  assign mul_sum  = mul_b_r[0] ? mul_acc_r + mul_a_r : mul_acc_r;
  assign mul_done = mul_busy_r && (mul_cnt_r == wzsd_pkg::STEP_W'(wzsd_pkg::MB_W - 1));

  always_comb begin
    unique case (cmd.mul_op)
      wzsd_pkg::MUL_NSQ: begin
        mul_a_in = wzsd_pkg::MP_W'(sumsq_r);
        mul_b_in = wzsd_pkg::MB_W'(n_r);
      end
      wzsd_pkg::MUL_SS: begin
        mul_a_in = wzsd_pkg::MP_W'(sum_r);
        mul_b_in = wzsd_pkg::MB_W'(sum_r);
      end
      wzsd_pkg::MUL_RHS: begin
        mul_a_in = wzsd_pkg::MP_W'(scaled);
        mul_b_in = scaled;
      end
      wzsd_pkg::MUL_VF: begin
        mul_a_in = wzsd_pkg::MP_W'(v_r);
        mul_b_in = wzsd_pkg::MB_W'(f2_r);
      end
      default: begin
        mul_a_in = '0;
        mul_b_in = '0;
      end
    endcase
  end

  // Binary search for the severity.
  logic [wzsd_pkg::SEV_W-1:0] lo_r, hi_r, mid_r, mid;
  logic [wzsd_pkg::SEV_W:0]   mid_sum;
  logic [wzsd_pkg::SEV_W+1:0] f5;
  logic [2*wzsd_pkg::SEV_W+3:0] f5_sq;

  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r} + 1'b1;
  assign mid     = mid_sum[wzsd_pkg::SEV_W:1];
  assign f5      = {2'b00, mid} * wzsd_pkg::SEV_SCALE;
  assign f5_sq   = f5 * f5;

  // Restoring divider for the average.
  logic [wzsd_pkg::DIVN_W-1:0] div_q_r, div_q_nxt;
  logic [wzsd_pkg::N_W-1:0]    div_rem_r, div_rem_nxt;
  logic [wzsd_pkg::N_W:0]      div_trial;
  logic [wzsd_pkg::STEP_W-1:0] div_cnt_r;
  logic                        div_busy_r, div_bit;
  logic [wzsd_pkg::AVG_W-1:0]  avg_r;

  assign div_trial   = {div_rem_r, div_q_r[wzsd_pkg::DIVN_W-1]};
  assign div_bit     = (div_trial >= {1'b0, n_r});
  assign div_rem_nxt = div_bit ? wzsd_pkg::N_W'(div_trial - {1'b0, n_r})
                               : div_trial[wzsd_pkg::N_W-1:0];
  assign div_q_nxt   = {div_q_r[wzsd_pkg::DIVN_W-2:0], div_bit};

  logic [CW+wzsd_pkg::CNTO_W-1:0] live_ext;
  assign live_ext = {{wzsd_pkg::CNTO_W{1'b0}}, count_r};

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r   <= wzsd_pkg::WINDOW_RST;
      oldest_r   <= '0;
      count_r    <= '0;
      p1_v_r     <= 1'b0;
      p2_v_r     <= 1'b0;
      p3_v_r     <= 1'b0;
      mul_busy_r <= 1'b0;
      mul_cnt_r  <= '0;
      div_busy_r <= 1'b0;
      div_cnt_r  <= '0;
      scan_idx_r <= '0;
    end else begin
      if (cfg_we) begin
        window_r <= cfg_data;
      end
      if (cmd.clear) begin
        oldest_r <= '0;
        count_r  <= '0;
      end else if (cmd.pop) begin
        oldest_r <= oldest_inc;
        count_r  <= count_r - 1'b1;
      end else if (ram_we) begin
        count_r <= count_r + 1'b1;
      end
      if (cmd.scan_init) begin
        scan_idx_r <= '0;
      end else if (scan_issue) begin
        scan_idx_r <= scan_idx_r + 1'b1;
      end
      p1_v_r <= scan_issue;
      p2_v_r <= p1_v_r && (rd_entry.key == in_r.term_key);
      p3_v_r <= p2_v_r;
      if (cmd.mul_start) begin
        mul_busy_r <= 1'b1;
        mul_cnt_r  <= '0;
      end else if (mul_done) begin
        mul_busy_r <= 1'b0;
      end else if (mul_busy_r) begin
        mul_cnt_r <= mul_cnt_r + 1'b1;
      end
      if (cmd.div_start) begin
        div_busy_r <= 1'b1;
        div_cnt_r  <= '0;
      end else if (div_busy_r) begin
        div_cnt_r <= div_cnt_r + 1'b1;
        if (div_cnt_r == wzsd_pkg::STEP_W'(wzsd_pkg::DIVN_W - 1)) begin
          div_busy_r <= 1'b0;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_r     <= in_data;
      status_r <= 1'b0;
      n_r      <= '0;
      avg_r    <= '0;
      lo_r     <= '0;
      hi_r     <= '0;
    end
    if (cmd.write_new && full) begin
      status_r <= 1'b1;
    end
    if (cmd.scan_init) begin
      scan_slot_r <= oldest_r;
      n_r         <= '0;
      sum_r       <= '0;
      sumsq_r     <= '0;
    end else begin
      if (scan_issue) begin
        scan_slot_r <= (scan_slot_r == AW'(WINDOW_DEPTH - 1)) ? '0 : scan_slot_r + 1'b1;
      end
      if (p3_v_r) begin
        n_r      <= n_r + 1'b1;
        sum_r    <= sum_r + wzsd_pkg::SUM_W'(f3_r);
        sumsq_r  <= sumsq_r + wzsd_pkg::SUMSQ_W'(sq_r);
        latest_r <= f3_r;
      end
    end
    f2s_r <= clamped;
    f3_r  <= f2s_r;
    sq_r  <= f2s_r * f2s_r;
    if (cmd.nl_calc) begin
      nl_r <= n_r * latest_r;
    end
    if (cmd.mul_start) begin
      mul_op_r  <= cmd.mul_op;
      mul_a_r   <= mul_a_in;
      mul_b_r   <= mul_b_in;
      mul_acc_r <= '0;
    end else if (mul_busy_r) begin
      mul_acc_r <= mul_sum;
      mul_a_r   <= {mul_a_r[wzsd_pkg::MP_W-2:0], 1'b0};
      mul_b_r   <= {1'b0, mul_b_r[wzsd_pkg::MB_W-1:1]};
    end
    if (mul_done) begin
      unique case (mul_op_r)
        wzsd_pkg::MUL_NSQ: nsq_r <= mul_sum[wzsd_pkg::V_W-1:0];
        wzsd_pkg::MUL_SS:  v_r   <= nsq_r - mul_sum[wzsd_pkg::V_W-1:0];
        wzsd_pkg::MUL_RHS: rhs_r <= mul_sum[wzsd_pkg::RHS_W-1:0];
        wzsd_pkg::MUL_VF: begin
          if (mul_sum <= wzsd_pkg::MP_W'(rhs_r)) begin
            lo_r <= mid_r;
          end else begin
            hi_r <= mid_r - 1'b1;
          end
        end
        default: ;
      endcase
    end
    if (cmd.sev_init) begin
      lo_r <= '0;
      hi_r <= wzsd_pkg::SEV_ONE;
    end
    if (cmd.sev_f2) begin
      mid_r <= mid;
      f2_r  <= f5_sq[wzsd_pkg::F2_W-1:0];
    end
    if (cmd.div_start) begin
      div_q_r   <= {sum_r, 8'h00};
      div_rem_r <= '0;
    end else if (div_busy_r) begin
      div_q_r   <= div_q_nxt;
      div_rem_r <= div_rem_nxt;
      if (div_cnt_r == wzsd_pkg::STEP_W'(wzsd_pkg::DIVN_W - 1)) begin
        avg_r <= div_q_nxt[wzsd_pkg::AVG_W-1:0];
      end
    end
    if (cmd.out_fire) begin
      out_r.severity          <= lo_r;
      out_r.average_frequency <= avg_r;
      out_r.match_count       <= n_r[wzsd_pkg::CNTO_W-1:0];
      out_r.live_entries      <= live_ext[wzsd_pkg::CNTO_W-1:0];
      out_r.status            <= status_r;
    end
  end

  assign stat.cnt_zero    = (count_r == '0);
  assign stat.expired     = (age > $signed({1'b0, window_r}));
  assign stat.scan_done   = (scan_idx_r == count_r) && !p1_v_r && !p2_v_r && !p3_v_r;
  assign stat.n_zero      = (n_r == '0);
  assign stat.mul_done    = mul_done;
  assign stat.sev_ok      = (nl_r > wzsd_pkg::NL_W'(sum_r)) && (v_r != '0);
  assign stat.search_open = (lo_r < hi_r);
  assign stat.div_busy    = div_busy_r;

  assign out_data = out_r;

  `WZSD_ASSERT_NOW(a_count_max, 1'b1, count_r <= CW'(WINDOW_DEPTH), "entry count beyond depth")
  `WZSD_ASSERT_NOW(a_pop_nonempty, cmd.pop, count_r != '0, "expiry popped an empty ring")
  `WZSD_ASSERT_NEXT(a_mul_quiet, mul_done && !cmd.mul_start, !mul_busy_r, "multiplier kept running")

endmodule
`default_nettype wire
